>>> sv/nearest_palette_color_yuv_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nearest palette color unit
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PALETTE_COLOR_YUV_UNIT_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_YUV_UNIT_DEFINES_SVH

// check a property on every rising edge outside reset
`define NPCYUV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition in one cycle implies a condition in the next one
`define NPCYUV_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

>>> sv/npcyuv_pkg.sv
// ----------------------------------------------------------------------------
// npcyuv_pkg
// Conversion coefficients and the fixed palette, held as precomputed YUV.
// ----------------------------------------------------------------------------
package npcyuv_pkg;

  localparam int TABLE_COLOURS = 16;
  localparam int IDX_W         = 4;
  localparam int COMP_W        = 16;
  localparam int ENTRY_W       = 3 * COMP_W;

  // Q15 coefficients, rounded to nearest
  localparam logic signed [15:0] CY_R = 16'sd9798;
  localparam logic signed [15:0] CY_G = 16'sd19235;
  localparam logic signed [15:0] CY_B = 16'sd3736;
  localparam logic signed [15:0] CU_R = -16'sd4644;
  localparam logic signed [15:0] CU_G = -16'sd9465;
  localparam logic signed [15:0] CU_B = 16'sd14287;
  localparam logic signed [15:0] CV_R = 16'sd20152;
  localparam logic signed [15:0] CV_G = -16'sd16875;
  localparam logic signed [15:0] CV_B = -16'sd3277;

  // ceil(2^32 / 255): exact floor division by 255 for operands below 2^24
  localparam logic [47:0] RECIP_255 = 48'd16843010;

  typedef logic [TABLE_COLOURS-1:0][ENTRY_W-1:0] pal_tab_t;

  localparam logic [23:0] RGB_TABLE [TABLE_COLOURS] = '{
    24'h002b36, 24'hcb4b16, 24'h586e75, 24'h657b83,
    24'h839496, 24'h6c71c4, 24'h93a1a1, 24'hfdf6e3,
    24'h4f545c, 24'hdc322f, 24'h859900, 24'hb58900,
    24'h268bd2, 24'hd33682, 24'h2aa198, 24'hffffff
  };

  // round acc/255 to nearest, then saturate to 16 bits
  function automatic logic [COMP_W-1:0] scale_const(input int acc);
    int q;
    if (acc >= 0) begin
      q = (acc + 127) / 255;
    end else begin
      q = -((-acc + 127) / 255);
    end
    if (q > 32767) begin
      q = 32767;
    end
    if (q < -32768) begin
      q = -32768;
    end
    return COMP_W'(q);
  endfunction

  // entry layout: Y in the top 16 bits, then U, then V
  function automatic pal_tab_t build_palette();
    pal_tab_t tab;
    int r;
    int g;
    int b;
    for (int i = 0; i < TABLE_COLOURS; i++) begin
      r = int'(RGB_TABLE[i][23:16]);
      g = int'(RGB_TABLE[i][15:8]);
      b = int'(RGB_TABLE[i][7:0]);
      tab[i] = {scale_const(int'(CY_R) * r + int'(CY_G) * g + int'(CY_B) * b),
                scale_const(int'(CU_R) * r + int'(CU_G) * g + int'(CU_B) * b),
                scale_const(int'(CV_R) * r + int'(CV_G) * g + int'(CV_B) * b)};
    end
    return tab;
  endfunction

  localparam pal_tab_t PAL_YUV = build_palette();

endpackage

>>> sv/nearest_palette_color_yuv_unit.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_yuv_unit
// Maps an RGBA pixel to the nearest entry of a fixed 16-color palette in YUV.
// ----------------------------------------------------------------------------
// After an opaque pixel is accepted, the unit forms the three YUV sums in
// S_ACC, runs the divide-by-255 through a shared reciprocal multiplier in
// S_DIV, and in S_SRCH the palette ROM, with its single read port, delivers
// one entry per cycle to a three-stage distance pipeline (read, square, sum
// and compare), the palette size capped at 16 entries. It takes no new pixel
// until it is back in S_IDLE. The result sits in an output register, so a new
// pixel is taken while the last result still waits. A pixel whose alpha is
// zero is dropped in S_IDLE and yields no result beat. Entry 0 is never
// chosen, and on equal distances the lower index wins.
module nearest_palette_color_yuv_unit
  import npcyuv_pkg::*;
#(
  parameter int PALETTE_SIZE = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // red_in [7:0], green_in [15:8], blue_in [23:16], alpha_in [31:24]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // palette_index [3:0], color_digit [6:4], ground_digit [9:7], zero [15:10]
  output logic [15:0] out_tdata
);

  // searched entries run from 1 up to LIMIT-1
  localparam int LIMIT = (PALETTE_SIZE > TABLE_COLOURS) ? TABLE_COLOURS : PALETTE_SIZE;
  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(LIMIT - 1);
  localparam logic [1:0]       DIV_LAST  = 2'd3;
  localparam logic [2:0]       GROUND_LO = 3'd4;
  localparam logic [2:0]       GROUND_HI = 3'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DIV,
    S_SRCH,
    S_OUT
  } state_t;

  // the palette, read through one registered port
  localparam pal_tab_t PAL_ROM = PAL_YUV;

  state_t            state_r;
  logic [1:0]        div_cnt_r;
  logic [IDX_W-1:0]  issue_idx_r;
  logic              issue_done_r;
  logic              out_tvalid_r;
  logic [15:0]       out_tdata_r;

  // pixel and conversion registers
  logic [7:0]               pix_red_r;
  logic [7:0]               pix_green_r;
  logic [7:0]               pix_blue_r;
  logic signed [24:0]       acc_r [3];
  logic [47:0]              prod_r;
  logic                     prod_neg_r;
  logic [1:0]               prod_comp_r;
  logic signed [COMP_W-1:0] px_r [3];

  // distance pipeline
  logic [ENTRY_W-1:0] rd_data_r;
  logic               rd_vld_r;
  logic               rd_last_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [31:0]        sq_r [3];
  logic               sq_vld_r;
  logic               sq_last_r;
  logic [IDX_W-1:0]   sq_idx_r;
  logic [33:0]        best_dist_r;
  logic [IDX_W-1:0]   best_idx_r;

  logic                     in_beat;
  logic                     issuing;
  logic signed [24:0]       s_red;
  logic signed [24:0]       s_green;
  logic signed [24:0]       s_blue;
  logic signed [24:0]       acc_nxt [3];
  logic signed [24:0]       acc_sel;
  logic [23:0]              mag_sel;
  logic signed [16:0]       q_signed;
  logic signed [COMP_W-1:0] q_sat;
  logic [33:0]              dist_nxt;
  logic                     take_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign issuing    = (state_r == S_SRCH) && !issue_done_r;

  // YUV sums: all operands signed, widened to the sum width
  assign s_red   = $signed({17'b0, pix_red_r});
  assign s_green = $signed({17'b0, pix_green_r});
  assign s_blue  = $signed({17'b0, pix_blue_r});

  always_comb begin
    acc_nxt[0] = 25'(CY_R) * s_red + 25'(CY_G) * s_green + 25'(CY_B) * s_blue;
    acc_nxt[1] = 25'(CU_R) * s_red + 25'(CU_G) * s_green + 25'(CU_B) * s_blue;
    acc_nxt[2] = 25'(CV_R) * s_red + 25'(CV_G) * s_green + 25'(CV_B) * s_blue;
  end

  // |acc| + 127 of the component entering the divider
  assign acc_sel = acc_r[div_cnt_r];
  assign mag_sel = acc_sel[24] ? 24'(-acc_sel) + 24'd127 : 24'(acc_sel) + 24'd127;

  // restore the sign and saturate to 16 bits
  always_comb begin
    q_signed = prod_neg_r ? -$signed({1'b0, prod_r[47:32]}) : $signed({1'b0, prod_r[47:32]});
    if (q_signed > 17'sd32767) begin
      q_sat = 16'sh7fff;
    end else if (q_signed < -17'sd32768) begin
      q_sat = -16'sh8000;
    end else begin
      q_sat = q_signed[15:0];
    end
  end

  assign dist_nxt = 34'(sq_r[0]) + 34'(sq_r[1]) + 34'(sq_r[2]);
  // first searched entry seeds the minimum; later ones must be strictly less
  assign take_nxt = (sq_idx_r == FIRST_IDX) || (dist_nxt < best_dist_r);

  // control: state, counters and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      div_cnt_r    <= '0;
      issue_idx_r  <= FIRST_IDX;
      issue_done_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      // free the output register; a result loaded in S_OUT takes its place
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          // drop transparent pixels right away
          if (in_beat && (in_tdata[31:24] != 8'd0)) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          div_cnt_r <= '0;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          div_cnt_r <= div_cnt_r + 2'd1;
          if (div_cnt_r == DIV_LAST) begin
            issue_idx_r  <= FIRST_IDX;
            issue_done_r <= 1'b0;
            state_r      <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (issuing) begin
            if (issue_idx_r == LAST_IDX) begin
              issue_done_r <= 1'b1;
            end else begin
              issue_idx_r <= issue_idx_r + IDX_W'(1);
            end
          end
          if (sq_vld_r && sq_last_r) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // hold the result until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {6'b0, (best_idx_r[3] ? GROUND_HI : GROUND_LO),
                             best_idx_r[2:0], best_idx_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // conversion datapath
  always_ff @(posedge clk) begin
    if (in_beat) begin
      pix_red_r   <= in_tdata[7:0];
      pix_green_r <= in_tdata[15:8];
      pix_blue_r  <= in_tdata[23:16];
    end
    if (state_r == S_ACC) begin
      acc_r[0] <= acc_nxt[0];
      acc_r[1] <= acc_nxt[1];
      acc_r[2] <= acc_nxt[2];
    end
    if (state_r == S_DIV) begin
      // multiply one component while the previous one is finished
      if (div_cnt_r != DIV_LAST) begin
        prod_r      <= 48'(mag_sel) * RECIP_255;
        prod_neg_r  <= acc_sel[24];
        prod_comp_r <= div_cnt_r;
      end
      if (div_cnt_r != 2'd0) begin
        px_r[prod_comp_r] <= q_sat;
      end
    end
  end

  // palette ROM read port
  always_ff @(posedge clk) begin
    rd_data_r <= PAL_ROM[issue_idx_r];
    rd_idx_r  <= issue_idx_r;
    rd_last_r <= (issue_idx_r == LAST_IDX);
  end

  // distance pipeline: square the differences, then sum and compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      sq_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issuing;
      sq_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      logic signed [16:0] diff;
      logic [15:0]        mag;
      diff = $signed({px_r[c][15], px_r[c]})
           - $signed({rd_data_r[(2-c)*COMP_W+15], rd_data_r[(2-c)*COMP_W +: COMP_W]});
      mag  = diff[16] ? 16'(-diff) : diff[15:0];
      sq_r[c] <= 32'(mag) * 32'(mag);
    end
    sq_idx_r  <= rd_idx_r;
    sq_last_r <= rd_last_r;
    if (sq_vld_r && take_nxt) begin
      best_dist_r <= dist_nxt;
      best_idx_r  <= sq_idx_r;
    end
  end

endmodule

>>> sv/npcyuv_checker.sv
// ----------------------------------------------------------------------------
// npcyuv_checker
// Port-level checks for the nearest palette color unit, bound to its top.
// ----------------------------------------------------------------------------
`include "nearest_palette_color_yuv_unit_defines.svh"

module npcyuv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled result beat stays up
  `NPCYUV_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "out beat dropped while stalled")

  // the digits always agree with the index, and index 0 never shows up
  `NPCYUV_ASSERT(a_out_fields, out_tvalid |-> (out_tdata[3:0] != 4'd0) && (out_tdata[6:4] == out_tdata[2:0]) && (out_tdata[9:7] == (out_tdata[3] ? 3'd3 : 3'd4)), "result fields disagree")

  // an opaque pixel keeps the unit busy for the next cycle
  `NPCYUV_ASSERT_NEXT(a_busy_after_pixel, in_tvalid && in_tready && (in_tdata[31:24] != 8'd0), !in_tready, "accepted a pixel while searching")

  // with no result pending, a result beat never appears in the cycle right after an opaque pixel
  `NPCYUV_ASSERT_NEXT(a_no_early_result, in_tvalid && in_tready && (in_tdata[31:24] != 8'd0) && !out_tvalid, !out_tvalid, "result before search finished")

endmodule

bind nearest_palette_color_yuv_unit npcyuv_checker u_npcyuv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
